>>> hw/rtl/iosfp_pkg.sv
package iosfp_pkg;

  localparam int MAX_FRAME        = 128;
  localparam int DIGITAL_CHANNELS = 16;
  localparam int ANALOG_CHANNELS  = 8;
  localparam int NUM_SLOTS        = 8;

  localparam logic [7:0] DELIM             = 8'h7E;
  localparam logic [7:0] KIND_IO_SAMPLE    = 8'h92;
  localparam logic [7:0] CHECK_BASE        = 8'hFF;
  localparam logic [7:0] BASE_WITH_DIGITAL = 8'd21;
  localparam logic [7:0] BASE_NO_DIGITAL   = 8'd19;
  localparam logic [7:0] POS_KIND          = 8'd3;
  localparam logic [7:0] POS_DMASK_HI      = 8'd16;
  localparam logic [7:0] POS_DMASK_LO      = 8'd17;
  localparam logic [7:0] POS_AMASK         = 8'd18;
  localparam logic [7:0] POS_DLEVEL_HI     = 8'd19;
  localparam logic [7:0] POS_DLEVEL_LO     = 8'd20;
  localparam logic [7:0] POS_LIMIT         = 8'hFF;
  localparam logic [7:0] SLOT_SPAN         = 8'd16;

  localparam logic [15:0] DIG_KEEP = 16'((32'd1 << DIGITAL_CHANNELS) - 32'd1);
  localparam logic [7:0]  ANA_KEEP = 8'((32'd1 << ANALOG_CHANNELS) - 32'd1);

  typedef logic [NUM_SLOTS-1:0][15:0] slot_arr_t;

  typedef struct packed {
    logic        open;
    logic [7:0]  pos;
    logic [7:0]  sum;
    logic [7:0]  last;
    logic [7:0]  kind;
    logic [15:0] dmask;
    logic [15:0] dlevel;
    logic [7:0]  amask;
  } frame_t;

  typedef struct packed {
    logic [15:0] digital_mask;
    logic [15:0] digital_levels;
    logic [7:0]  analog_mask;
    slot_arr_t   analog;
  } res_t;

endpackage

>>> hw/rtl/iosfp_track.sv
module iosfp_track
  import iosfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data,
  output frame_t     frame,
  output slot_arr_t  slots
);

  logic [7:0] pos_next;
  logic       store_en;
  logic [7:0] base;
  logic [7:0] off;
  logic       in_window;

  always_comb begin
    pos_next  = (frame.pos != POS_LIMIT) ? frame.pos + 8'd1 : frame.pos;
    store_en  = (frame.pos != POS_LIMIT) && ({1'b0, pos_next} < 9'(MAX_FRAME));
    base      = (frame.dmask != '0) ? BASE_WITH_DIGITAL : BASE_NO_DIGITAL;
    off       = pos_next - base;
    in_window = (pos_next >= base) && (pos_next < base + SLOT_SPAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
      slots <= '0;
    end else if (step) begin
      if (data == DELIM) begin
        frame.open   <= 1'b1;
        frame.pos    <= '0;
        frame.sum    <= '0;
        frame.last   <= DELIM;
        frame.kind   <= '0;
        frame.dmask  <= '0;
        frame.dlevel <= '0;
        frame.amask  <= '0;
        slots        <= '0;
      end else if (frame.open) begin
        frame.pos  <= pos_next;
        frame.last <= data;
        if (pos_next >= POS_KIND) begin
          frame.sum <= frame.sum + data;
        end
        if (store_en) begin
          if (pos_next == POS_KIND)      frame.kind         <= data;
          if (pos_next == POS_DMASK_HI)  frame.dmask[15:8]  <= data;
          if (pos_next == POS_DMASK_LO)  frame.dmask[7:0]   <= data;
          if (pos_next == POS_AMASK)     frame.amask        <= data;
          if (pos_next == POS_DLEVEL_HI) frame.dlevel[15:8] <= data;
          if (pos_next == POS_DLEVEL_LO) frame.dlevel[7:0]  <= data;
          if (in_window) begin
            if (off[0] == 1'b0) begin
              slots[off[3:1]][15:8] <= data;
            end else begin
              slots[off[3:1]][7:0] <= data;
            end
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/iosfp_close.sv
module iosfp_close
  import iosfp_pkg::*;
(
  input  frame_t    frame,
  input  slot_arr_t slots,
  output logic      ok,
  output res_t      res
);

  logic [7:0] body;
  logic [7:0] expect_sum;
  logic [7:0] amask;
  logic [2:0] j;

  always_comb begin
    body       = frame.sum - frame.last;
    expect_sum = CHECK_BASE - body;
    ok = frame.open && (frame.kind == KIND_IO_SAMPLE) && (frame.pos != '0) &&
         (expect_sum == frame.last);

    amask              = frame.amask & ANA_KEEP;
    res.digital_mask   = frame.dmask & DIG_KEEP;
    res.digital_levels = frame.dlevel & frame.dmask & DIG_KEEP;
    res.analog_mask    = amask;
    j = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (amask[i]) begin
        res.analog[i] = slots[j];
        j = j + 3'd1;
      end else begin
        res.analog[i] = '0;
      end
    end
  end

endmodule

>>> hw/rtl/io_sample_frame_parser_top.sv
// Parses a received byte stream into I/O sample frames. One byte is taken per
// item and a new byte can be accepted on every cycle unless the input stalls
// as described below; a byte passes an input register and updates the frame
// state, and a closing delimiter then loads the result register, from which
// the result is offered. Input stalls only when a delimiter waits on a result
// register that has not yet been taken; other bytes pass regardless of
// res_ready. A result is given only for a frame of type 0x92 with a good
// checksum; frames still open and bytes before the first delimiter give
// nothing.
module io_sample_frame_parser_top
  import iosfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [15:0] digital_mask,
  output logic [15:0] digital_levels,
  output logic [7:0]  analog_mask,
  output logic [15:0] analog_ch0,
  output logic [15:0] analog_ch1,
  output logic [15:0] analog_ch2,
  output logic [15:0] analog_ch3,
  output logic [15:0] analog_ch4,
  output logic [15:0] analog_ch5,
  output logic [15:0] analog_ch6,
  output logic [15:0] analog_ch7
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_delim;
  logic       advance;
  frame_t     frame;
  slot_arr_t  slots;
  logic       close_ok;
  res_t       close_res;
  res_t       res;

  assign in_delim = (in_byte == DELIM);
  assign advance  = in_valid && (!in_delim || !res_valid || res_ready);
  assign rx_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_ready) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      in_byte <= rx_byte;
    end
  end

  iosfp_track u_track (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .data  (in_byte),
    .frame (frame),
    .slots (slots)
  );

  iosfp_close u_close (
    .frame (frame),
    .slots (slots),
    .ok    (close_ok),
    .res   (close_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_delim) begin
      res_valid <= close_ok;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_delim && close_ok) begin
      res <= close_res;
    end
  end

  assign digital_mask   = res.digital_mask;
  assign digital_levels = res.digital_levels;
  assign analog_mask    = res.analog_mask;
  assign analog_ch0     = res.analog[0];
  assign analog_ch1     = res.analog[1];
  assign analog_ch2     = res.analog[2];
  assign analog_ch3     = res.analog[3];
  assign analog_ch4     = res.analog[4];
  assign analog_ch5     = res.analog[5];
  assign analog_ch6     = res.analog[6];
  assign analog_ch7     = res.analog[7];

endmodule

>>> hw/rtl/iosfp_checker.sv
module iosfp_checker
  import iosfp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic [7:0]  rx_byte,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] digital_mask,
  input logic [15:0] digital_levels,
  input logic [7:0]  analog_mask,
  input logic [15:0] analog_ch0,
  input logic [15:0] analog_ch1,
  input logic [15:0] analog_ch2,
  input logic [15:0] analog_ch3,
  input logic [15:0] analog_ch4,
  input logic [15:0] analog_ch5,
  input logic [15:0] analog_ch6,
  input logic [15:0] analog_ch7
);

  // stalled result stays valid; masks, levels and channel 0 hold
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(digital_mask) &&
      $stable(digital_levels) && $stable(analog_mask) && $stable(analog_ch0))
    else $error("stalled result changed");

  // input only stalls behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid && !res_ready)
    else $error("input stalled without a waiting result");

  // levels only where mask bits are set
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (digital_levels & ~digital_mask) == 16'h0000)
    else $error("digital level outside mask");

  // absent analog channels read zero
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (analog_mask[0] || analog_ch0 == 16'h0000) &&
      (analog_mask[1] || analog_ch1 == 16'h0000) &&
      (analog_mask[2] || analog_ch2 == 16'h0000) &&
      (analog_mask[3] || analog_ch3 == 16'h0000) &&
      (analog_mask[4] || analog_ch4 == 16'h0000) &&
      (analog_mask[5] || analog_ch5 == 16'h0000) &&
      (analog_mask[6] || analog_ch6 == 16'h0000) &&
      (analog_mask[7] || analog_ch7 == 16'h0000))
    else $error("absent analog channel nonzero");

  // a new result follows a delimiter item
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(rx_valid && rx_ready && rx_byte == DELIM, 2))
    else $error("result without a delimiter");

endmodule

bind io_sample_frame_parser_top iosfp_checker u_iosfp_checker (.*);

>>> tb/io_sample_frame_parser_top_tb.sv
`timescale 1ns / 100ps

module io_sample_frame_parser_top_tb;
  import iosfp_pkg::*;

  localparam int STREAM_ITEMS = 1500;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [15:0] digital_mask;
  logic [15:0] digital_levels;
  logic [7:0]  analog_mask;
  logic [15:0] analog_ch0, analog_ch1, analog_ch2, analog_ch3;
  logic [15:0] analog_ch4, analog_ch5, analog_ch6, analog_ch7;
  slot_arr_t   got_analog;

  logic [7:0]  rx_stream[$];
  res_t        pending_frames[$];
  int          n_err = 0;
  int          rx_gap = 0;
  int          res_gap = 0;
  int          cycles = 0;

  // parser state mirror
  logic        fr_open;
  logic [7:0]  fr_pos;
  logic [7:0]  fr_sum;
  logic [7:0]  fr_last;
  logic [7:0]  fr_kind;
  logic [15:0] fr_dmask;
  logic [15:0] fr_dlevel;
  logic [7:0]  fr_amask;
  logic [15:0] fr_slot[NUM_SLOTS];

  assign got_analog = {analog_ch7, analog_ch6, analog_ch5, analog_ch4,
                       analog_ch3, analog_ch2, analog_ch1, analog_ch0};

  io_sample_frame_parser_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_ready       (rx_ready),
    .rx_byte        (rx_byte),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .digital_mask   (digital_mask),
    .digital_levels (digital_levels),
    .analog_mask    (analog_mask),
    .analog_ch0     (analog_ch0),
    .analog_ch1     (analog_ch1),
    .analog_ch2     (analog_ch2),
    .analog_ch3     (analog_ch3),
    .analog_ch4     (analog_ch4),
    .analog_ch5     (analog_ch5),
    .analog_ch6     (analog_ch6),
    .analog_ch7     (analog_ch7)
  );

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == DELIM) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic add_frame(input logic [15:0] dmask, input logic [7:0] amask,
                           input bit kind_ok, input bit sum_ok, input int pad);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] chk;
    body.push_back(8'h00);
    body.push_back(data_byte());
    body.push_back(kind_ok ? KIND_IO_SAMPLE : data_byte());
    repeat (11) body.push_back(data_byte());
    body.push_back(8'h01);
    body.push_back(dmask[15:8]);
    body.push_back(dmask[7:0]);
    body.push_back(amask);
    if (dmask != 16'h0000) begin
      body.push_back(data_byte());
      body.push_back(data_byte());
    end
    for (int i = 0; i < 8; i++) begin
      if (amask[i]) begin
        body.push_back(data_byte());
        body.push_back(data_byte());
      end
    end
    repeat (pad) body.push_back(data_byte());
    // a checksum equal to the delimiter would split the frame
    chk = DELIM;
    while (chk == DELIM) begin
      sum = 8'h00;
      for (int i = 2; i < body.size(); i++) sum = sum + body[i];
      chk = CHECK_BASE - sum;
      if (chk == DELIM) body[4] = data_byte();
    end
    if (!sum_ok) chk = chk + 8'($urandom_range(1, 255));
    rx_stream.push_back(DELIM);
    foreach (body[i]) rx_stream.push_back(body[i]);
    rx_stream.push_back(chk);
  endtask

  task automatic track_byte(input logic [7:0] b);
    res_t       want;
    logic [7:0] body;
    logic [7:0] base;
    logic [7:0] off;
    logic [7:0] amask;
    int         j;
    if (b == DELIM) begin
      if (fr_open) begin
        body = fr_sum - fr_last;
        if (fr_kind == KIND_IO_SAMPLE && fr_pos != 8'd0 && CHECK_BASE - body == fr_last) begin
          amask = fr_amask & ANA_KEEP;
          want.digital_mask   = fr_dmask & DIG_KEEP;
          want.digital_levels = fr_dlevel & fr_dmask & DIG_KEEP;
          want.analog_mask    = amask;
          j = 0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (amask[i]) begin
              want.analog[i] = fr_slot[j];
              j++;
            end else begin
              want.analog[i] = 16'h0000;
            end
          end
          pending_frames.push_back(want);
        end
      end
      fr_open   = 1'b1;
      fr_pos    = 8'd0;
      fr_sum    = 8'd0;
      fr_last   = DELIM;
      fr_kind   = 8'd0;
      fr_dmask  = 16'h0000;
      fr_dlevel = 16'h0000;
      fr_amask  = 8'd0;
      foreach (fr_slot[i]) fr_slot[i] = 16'h0000;
    end else if (fr_open) begin
      if (fr_pos != POS_LIMIT) begin
        fr_pos = fr_pos + 8'd1;
        if (fr_pos < MAX_FRAME) begin
          case (fr_pos)
            POS_KIND:      fr_kind          = b;
            POS_DMASK_HI:  fr_dmask[15:8]   = b;
            POS_DMASK_LO:  fr_dmask[7:0]    = b;
            POS_AMASK:     fr_amask         = b;
            POS_DLEVEL_HI: fr_dlevel[15:8]  = b;
            POS_DLEVEL_LO: fr_dlevel[7:0]   = b;
            default: ;
          endcase
          base = (fr_dmask != 16'h0000) ? BASE_WITH_DIGITAL : BASE_NO_DIGITAL;
          if (fr_pos >= base && fr_pos < base + SLOT_SPAN) begin
            off = fr_pos - base;
            if (off[0]) fr_slot[off[3:1]][7:0]  = b;
            else        fr_slot[off[3:1]][15:8] = b;
          end
        end
      end
      if (fr_pos >= POS_KIND) fr_sum = fr_sum + b;
      fr_last = b;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_err++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      rx_byte  <= 8'h00;
    end else if (!rx_valid || rx_ready) begin
      if (rx_gap == 0 && rx_stream.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
        rx_gap = $urandom_range(1, 5);
      if (rx_gap > 0) begin
        rx_gap--;
        rx_valid <= 1'b0;
      end else if (rx_stream.size() > 0) begin
        rx_valid <= 1'b1;
        rx_byte  <= rx_stream.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // result stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_gap == 0 && rx_stream.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
        res_gap = $urandom_range(1, 5);
      if (res_gap > 0) begin
        res_gap--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      fr_open   = 1'b0;
      fr_pos    = 8'd0;
      fr_sum    = 8'd0;
      fr_last   = 8'd0;
      fr_kind   = 8'd0;
      fr_dmask  = 16'h0000;
      fr_dlevel = 16'h0000;
      fr_amask  = 8'd0;
      foreach (fr_slot[i]) fr_slot[i] = 16'h0000;
    end else begin
      if (rx_valid && rx_ready) track_byte(rx_byte);
      if (res_valid && res_ready) begin
        if (pending_frames.size() == 0) begin
          $error("result with no frame pending");
          n_err++;
        end else begin
          want = pending_frames.pop_front();
          check_field("digital_mask", want.digital_mask, digital_mask);
          check_field("digital_levels", want.digital_levels, digital_levels);
          check_field("analog_mask", {8'h00, want.analog_mask}, {8'h00, analog_mask});
          for (int i = 0; i < NUM_SLOTS; i++)
            check_field($sformatf("analog_ch%0d", i), want.analog[i], got_analog[i]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [15:0] dm;
    logic [7:0]  am;
    int          pick;

    // junk before the first delimiter, a lone delimiter, a short frame
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(DELIM);
    rx_stream.push_back(DELIM);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'h12);
    add_frame(16'hFFFF, 8'hFF, 1'b1, 1'b1, 0);
    add_frame(16'h0000, 8'h00, 1'b1, 1'b1, 0);
    add_frame(16'h0000, 8'h81, 1'b1, 1'b1, 0);
    add_frame(16'h0001, 8'h01, 1'b0, 1'b1, 0);
    add_frame(16'h8000, 8'h80, 1'b1, 1'b0, 0);
    // long frame, position saturates
    add_frame(16'h00FF, 8'h0F, 1'b1, 1'b1, 300);

    while (rx_stream.size() < STREAM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       dm = 16'h0000;
        1:       dm = 16'hFFFF;
        default: dm = {data_byte(), data_byte()};
      endcase
      case ($urandom_range(0, 3))
        0:       am = 8'h00;
        1:       am = 8'hFF;
        default: am = data_byte();
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        repeat ($urandom_range(1, 30)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        rx_stream.push_back(DELIM);
        repeat ($urandom_range(1, 25)) rx_stream.push_back(data_byte());
      end else begin
        add_frame(dm, am, pick != 2, pick != 3,
                  (pick == 4 && $urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(0, 3));
      end
    end
    rx_stream.push_back(DELIM);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (rx_stream.size() != 0 || rx_valid || pending_frames.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
